/* src/pose_gesture_template_matcher_top_assert.svh */
// assertion macros for the gesture matcher
`ifndef POSE_GESTURE_TEMPLATE_MATCHER_TOP_ASSERT_SVH
`define POSE_GESTURE_TEMPLATE_MATCHER_TOP_ASSERT_SVH

// condition that must hold at every clock outside reset
`define PGTM_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("pgtm: check failed");

// consequence that must hold in the same cycle as its cause
`define PGTM_ASSERT_IMPLY(label, cause, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |-> (conseq)) \
    else $error("pgtm: implication failed");

`endif

/* src/pgtm_pkg.sv */
package pgtm_pkg;

  localparam int JOINTS      = 512;
  localparam int JW          = 9;
  localparam int FRAMES      = 32;
  localparam int FW          = 5;
  localparam int GESTURES    = 8;
  localparam int GW          = 3;
  localparam int HIST        = 32;
  localparam int HW          = 5;
  localparam int SKIP        = 6;
  localparam int VW          = 24;

  // command codes, equal to the kind field
  localparam logic [1:0] OP_TVAL  = 2'd0;
  localparam logic [1:0] OP_TLEN  = 2'd1;
  localparam logic [1:0] OP_PVAL  = 2'd2;
  localparam logic [1:0] OP_CHECK = 2'd3;

  // register indexes
  localparam logic [2:0] REG_JOINTS   = 3'd0;
  localparam logic [2:0] REG_DEPTH    = 3'd1;
  localparam logic [2:0] REG_MATCH    = 3'd2;
  localparam logic [2:0] REG_ACTIVITY = 3'd3;
  localparam logic [2:0] REG_PERCENT  = 3'd4;
  localparam logic [2:0] REG_COOLDOWN = 3'd5;

  typedef struct packed {
    logic [1:0]          op;
    logic [GW-1:0]       gesture;
    logic [FW-1:0]       frame;
    logic [JW-1:0]       joint;
    logic signed [VW-1:0] value;
    logic [5:0]          count;
    logic                eof;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_stat_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctl_t;

  function automatic logic [VW:0] absdiff(input logic signed [VW-1:0] a,
                                          input logic signed [VW-1:0] b);
    logic signed [VW:0] d;
    d = {a[VW-1], a} - {b[VW-1], b};
    return d[VW] ? (VW+1)'(-d) : (VW+1)'(d);
  endfunction

endpackage

/* src/pgtm_front.sv */
module pgtm_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   kind,
  input  logic [2:0]                   gesture_index,
  input  logic [4:0]                   frame_index,
  input  logic [8:0]                   joint_index,
  input  logic signed [23:0]           joint_value,
  input  logic [5:0]                   frame_count,
  input  logic                         end_of_frame,
  input  pgtm_pkg::back_ctl_t          ctl,
  output pgtm_pkg::q_stat_t            q
);

  pgtm_pkg::cmd_t fifo [2];
  pgtm_pkg::cmd_t dec;
  logic           wp;
  logic           rp;
  logic [1:0]     cnt;
  logic           push;

  // classify the word and saturate the template length
  always_comb begin
    dec.gesture = gesture_index;
    dec.frame   = frame_index;
    dec.joint   = joint_index;
    dec.value   = joint_value;
    dec.eof     = end_of_frame;
    dec.count   = (frame_count > 6'(pgtm_pkg::FRAMES)) ? 6'(pgtm_pkg::FRAMES) : frame_count;
    unique case (kind)
      pgtm_pkg::OP_TVAL:  dec.op = pgtm_pkg::OP_TVAL;
      pgtm_pkg::OP_TLEN:  dec.op = pgtm_pkg::OP_TLEN;
      pgtm_pkg::OP_PVAL:  dec.op = pgtm_pkg::OP_PVAL;
      default:            dec.op = pgtm_pkg::OP_CHECK;
    endcase
  end

  assign in_ready = (cnt != 2'd2) && !ctl.clearing;
  assign push     = in_valid && in_ready;
  assign q.valid  = (cnt != 2'd0);
  assign q.cmd    = fifo[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wp] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (ctl.pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(ctl.pop);
    end
  end

endmodule

/* src/pgtm_back.sv */
module pgtm_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [22:0]          cfg_data,
  input  pgtm_pkg::q_stat_t    q,
  output pgtm_pkg::back_ctl_t  ctl,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [3:0]           detected_gesture,
  output logic [5:0]           matched_frames,
  output logic [5:0]           gesture_frames
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MARK  = 3'd2;
  localparam logic [2:0] S_COPY  = 3'd3;
  localparam logic [2:0] S_GSEL  = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_DEC   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  localparam logic [9:0] JEND  = 10'(pgtm_pkg::JOINTS);
  localparam logic [9:0] JSKIP = 10'(pgtm_pkg::SKIP);
  localparam logic [2:0] GLAST = 3'(pgtm_pkg::GESTURES - 1);

  logic [2:0]  state;

  logic [9:0]  joints_in_use;
  logic [5:0]  history_depth;
  logic [22:0] match_threshold;
  logic [22:0] activity_threshold;
  logic [6:0]  detect_percent;
  logic [7:0]  cooldown_checks;

  logic [5:0]  tlen      [pgtm_pkg::GESTURES];
  logic [31:0] last_time [pgtm_pkg::GESTURES];
  logic [31:0] ckcnt;
  logic [4:0]  head;
  logic [5:0]  hcount;

  logic signed [23:0] tmem [pgtm_pkg::GESTURES*pgtm_pkg::FRAMES*pgtm_pkg::JOINTS];
  logic signed [23:0] hmem [pgtm_pkg::HIST*pgtm_pkg::JOINTS];
  logic signed [23:0] pmem [pgtm_pkg::JOINTS];
  logic               amem [pgtm_pkg::GESTURES*pgtm_pkg::JOINTS];
  logic signed [23:0] trd;
  logic signed [23:0] hrd;
  logic signed [23:0] prd;
  logic               ard;

  pgtm_pkg::cmd_t cur;
  logic [2:0]  cg;
  logic [9:0]  cj;
  logic [5:0]  cf;
  logic        u_v;
  logic        u_first;
  logic        u_last;
  logic [8:0]  u_j;
  logic        acc;
  logic signed [23:0] t0;
  logic [5:0]  hit_cnt;
  logic        cp_wv;
  logic [8:0]  cp_wj;
  logic [3:0]  res_g;
  logic [5:0]  res_m;
  logic [5:0]  res_l;

  logic [9:0]  jlim;
  logic [5:0]  dlim;
  logic [5:0]  dnew;
  logic [5:0]  len_m;
  logic [4:0]  mark_lm1;
  logic [5:0]  len_c;
  logic [4:0]  slot;
  logic        acc_mark;
  logic        mask_bit;
  logic        bad_cur;
  logic        cool_skip;
  logic        fits;
  logic        trig;
  logic        t_we;
  logic [16:0] t_raddr;
  logic        p_we;
  logic [8:0]  p_waddr;
  logic signed [23:0] p_wdata;
  logic        a_we;
  logic        take;

  always_comb begin
    jlim = (joints_in_use > JEND) ? JEND : joints_in_use;
    if (history_depth == 6'd0) dlim = 6'd1;
    else if (history_depth > 6'(pgtm_pkg::HIST)) dlim = 6'(pgtm_pkg::HIST);
    else dlim = history_depth;
    if (cfg_data[5:0] == 6'd0) dnew = 6'd1;
    else if (cfg_data[5:0] > 6'(pgtm_pkg::HIST)) dnew = 6'(pgtm_pkg::HIST);
    else dnew = cfg_data[5:0];
  end

  assign len_m    = tlen[cur.gesture];
  assign mark_lm1 = (len_m == 6'd0) ? 5'd0 : 5'(len_m - 6'd1);
  assign len_c    = tlen[cg];
  assign slot     = head + cf[4:0] - len_c[4:0];

  // activity scan: first frame loads the reference, later frames compare with it
  assign acc_mark = u_first ? 1'b0
                  : (acc | (pgtm_pkg::absdiff(trd, t0) > {2'b0, activity_threshold}));
  assign mask_bit = acc_mark && ({1'b0, u_j} >= JSKIP) && ({1'b0, u_j} < jlim)
                  && (len_m != 6'd0);
  assign bad_cur  = acc | (ard && (pgtm_pkg::absdiff(trd, hrd) > {2'b0, match_threshold}));

  assign cool_skip = (last_time[cg] <= ckcnt)
                  && ((ckcnt - last_time[cg]) < {24'd0, cooldown_checks});
  assign fits      = (hcount != 6'd0) && (hcount >= len_c);
  assign trig      = (13'(hit_cnt) * 13'd100) >= (13'(detect_percent) * 13'(len_c));

  assign take      = (state == S_IDLE) && q.valid;
  assign ctl.pop   = take;
  assign ctl.clearing = (state == S_CLEAR);
  assign cfg_ready = 1'b1;

  assign t_we    = take && (q.cmd.op == pgtm_pkg::OP_TVAL);
  assign t_raddr = (state == S_MARK) ? {cur.gesture, cf[4:0], cj[8:0]} : {cg, cf[4:0], cj[8:0]};
  assign a_we    = (state == S_MARK) && u_v && u_last;

  always_comb begin
    if (state == S_CLEAR) begin
      p_we    = 1'b1;
      p_waddr = cj[8:0];
      p_wdata = '0;
    end else begin
      p_we    = take && (q.cmd.op == pgtm_pkg::OP_PVAL);
      p_waddr = q.cmd.joint;
      p_wdata = q.cmd.value;
    end
  end

  always_ff @(posedge clk) begin
    if (t_we) tmem[{q.cmd.gesture, q.cmd.frame, q.cmd.joint}] <= q.cmd.value;
    trd <= tmem[t_raddr];
  end

  always_ff @(posedge clk) begin
    if (cp_wv) hmem[{head, cp_wj}] <= prd;
    hrd <= hmem[{slot, cj[8:0]}];
  end

  always_ff @(posedge clk) begin
    if (p_we) pmem[p_waddr] <= p_wdata;
    prd <= pmem[cj[8:0]];
  end

  always_ff @(posedge clk) begin
    if (a_we) amem[{cur.gesture, u_j}] <= mask_bit;
    ard <= amem[{cg, cj[8:0]}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_CLEAR;
      joints_in_use      <= 10'd512;
      history_depth      <= 6'd32;
      match_threshold    <= 23'd2560;
      activity_threshold <= 23'd6400;
      detect_percent     <= 7'd75;
      cooldown_checks    <= 8'd20;
      for (int i = 0; i < pgtm_pkg::GESTURES; i++) begin
        tlen[i]      <= '0;
        last_time[i] <= '0;
      end
      ckcnt     <= '0;
      head      <= '0;
      hcount    <= '0;
      cj        <= '0;
      cf        <= '0;
      cg        <= '0;
      u_v       <= 1'b0;
      cp_wv     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (cj == JEND - 10'd1) begin
            cj    <= '0;
            state <= S_IDLE;
          end else begin
            cj <= cj + 10'd1;
          end
        end
        S_IDLE: begin
          if (take) begin
            cur <= q.cmd;
            case (q.cmd.op)
              pgtm_pkg::OP_TLEN: begin
                tlen[q.cmd.gesture] <= q.cmd.count;
                cj    <= '0;
                cf    <= '0;
                u_v   <= 1'b0;
                state <= S_MARK;
              end
              pgtm_pkg::OP_PVAL: begin
                if (q.cmd.eof) begin
                  cj    <= '0;
                  cp_wv <= 1'b0;
                  state <= S_COPY;
                end
              end
              pgtm_pkg::OP_CHECK: begin
                ckcnt <= ckcnt + 32'd1;
                cg    <= '0;
                state <= S_GSEL;
              end
              default: ;
            endcase
          end
        end
        S_MARK: begin
          if (cj != JEND) begin
            u_v     <= 1'b1;
            u_first <= (cf == 6'd0);
            u_last  <= (cf[4:0] == mark_lm1);
            u_j     <= cj[8:0];
            if (cf[4:0] == mark_lm1) begin
              cf <= '0;
              cj <= cj + 10'd1;
            end else begin
              cf <= cf + 6'd1;
            end
          end else begin
            u_v <= 1'b0;
            if (!u_v) state <= S_IDLE;
          end
          if (u_v) begin
            acc <= acc_mark;
            if (u_first) t0 <= trd;
          end
        end
        S_COPY: begin
          if (cj != JEND) begin
            cj    <= cj + 10'd1;
            cp_wv <= 1'b1;
            cp_wj <= cj[8:0];
          end else begin
            cp_wv <= 1'b0;
            if (!cp_wv) begin
              head <= head + 5'd1;
              if (hcount < dlim) hcount <= hcount + 6'd1;
              state <= S_IDLE;
            end
          end
        end
        S_GSEL: begin
          if (len_c == 6'd0 || cool_skip || !fits) begin
            if (cg == GLAST) begin
              res_g <= '0;
              res_m <= '0;
              res_l <= '0;
              state <= S_DONE;
            end else begin
              cg <= cg + 3'd1;
            end
          end else if (jlim <= JSKIP) begin
            hit_cnt <= len_c;
            state   <= S_DEC;
          end else begin
            cf      <= '0;
            cj      <= JSKIP;
            hit_cnt <= '0;
            acc     <= 1'b0;
            u_v     <= 1'b0;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cf != len_c) begin
            u_v    <= 1'b1;
            u_last <= (cj == jlim - 10'd1);
            if (cj == jlim - 10'd1) begin
              cj <= JSKIP;
              cf <= cf + 6'd1;
            end else begin
              cj <= cj + 10'd1;
            end
          end else begin
            u_v <= 1'b0;
            if (!u_v) state <= S_DEC;
          end
          if (u_v) begin
            if (u_last) begin
              acc <= 1'b0;
              if (!bad_cur) hit_cnt <= hit_cnt + 6'd1;
            end else begin
              acc <= bad_cur;
            end
          end
        end
        S_DEC: begin
          if (trig) begin
            last_time[cg] <= ckcnt;
            res_g <= {1'b0, cg} + 4'd1;
            res_m <= hit_cnt;
            res_l <= len_c;
            state <= S_DONE;
          end else if (cg == GLAST) begin
            res_g <= '0;
            res_m <= '0;
            res_l <= '0;
            state <= S_DONE;
          end else begin
            cg    <= cg + 3'd1;
            state <= S_GSEL;
          end
        end
        default: begin
          if (!out_valid || out_ready) state <= S_IDLE;
        end
      endcase

      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid        <= 1'b1;
        detected_gesture <= res_g;
        matched_frames   <= res_m;
        gesture_frames   <= res_l;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_valid) begin
        case (cfg_index)
          pgtm_pkg::REG_JOINTS:   joints_in_use <= cfg_data[9:0];
          pgtm_pkg::REG_DEPTH: begin
            history_depth <= cfg_data[5:0];
            if (hcount > dnew) hcount <= dnew;
          end
          pgtm_pkg::REG_MATCH:    match_threshold    <= cfg_data;
          pgtm_pkg::REG_ACTIVITY: activity_threshold <= cfg_data;
          pgtm_pkg::REG_PERCENT:  detect_percent     <= cfg_data[6:0];
          pgtm_pkg::REG_COOLDOWN: cooldown_checks    <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

endmodule

/* src/pose_gesture_template_matcher_top.sv */
// gesture template matcher: template values, template lengths, pose values and
// check commands arrive as words on one channel, pass a two-word queue and are
// carried out by a sequencer over block memories (templates, pose history,
// pending pose frame, per-gesture active-joint masks), each with one write and
// one registered read port. after reset a clearing pass zeroes the pending
// frame; no word is taken meanwhile (configuration writes always are). a pose
// value closing a frame copies the pending frame into the history; a template
// length rescans the slot against its frame 0 (one template read per cycle); a
// check walks the gestures in slot order and stops at the first that triggers,
// its pace set by the single template and history read ports. exactly one
// result word follows each check, held in an output register until taken
module pose_gesture_template_matcher_top (
  input  logic                 clk,
  input  logic                 rst,
  // command words
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           kind,
  input  logic [2:0]           gesture_index,
  input  logic [4:0]           frame_index,
  input  logic [8:0]           joint_index,
  input  logic signed [23:0]   joint_value,
  input  logic [5:0]           frame_count,
  input  logic                 end_of_frame,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [22:0]          cfg_data,
  // check results
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [3:0]           detected_gesture,
  output logic [5:0]           matched_frames,
  output logic [5:0]           gesture_frames
);

`include "pose_gesture_template_matcher_top_assert.svh"

  // queue head towards the sequencer, pop and clearing status back
  pgtm_pkg::q_stat_t   q;
  pgtm_pkg::back_ctl_t ctl;

  // front: classifies words and queues them
  pgtm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .gesture_index (gesture_index),
    .frame_index   (frame_index),
    .joint_index   (joint_index),
    .joint_value   (joint_value),
    .frame_count   (frame_count),
    .end_of_frame  (end_of_frame),
    .ctl           (ctl),
    .q             (q)
  );

  // back: memories, sequencer and result register
  pgtm_back u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .q                (q),
    .ctl              (ctl),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .detected_gesture (detected_gesture),
    .matched_frames   (matched_frames),
    .gesture_frames   (gesture_frames)
  );

  // no word enters while the pending frame is being cleared
  `PGTM_ASSERT_IMPLY(a_no_take_clearing, ctl.clearing, !in_ready)
  // the sequencer only pops a queue that holds a word
  `PGTM_ASSERT_IMPLY(a_pop_has_word, ctl.pop, q.valid)
  // a result with no gesture carries no counts
  `PGTM_ASSERT_IMPLY(a_none_is_zero, out_valid && detected_gesture == 4'd0,
    matched_frames == 6'd0 && gesture_frames == 6'd0)
  // a trigger never counts more matches than frames
  `PGTM_ASSERT_ALWAYS(a_matches_bounded, !out_valid || matched_frames <= gesture_frames)

endmodule
